/* hdl/wmse_pkg.sv */
// wmse_pkg: types, widths, register codes and reset values for the windowed
// MSE attack detector. No dependencies; used by the top level and its checker.

package wmse_pkg;

  // Field widths
  localparam int SAMPLE_WIDTH        = 24;   // Q16.8 samples
  localparam int MSE_WIDTH           = 63;   // Q47.16 error sum / MSE
  localparam int CNT_WIDTH           = 16;   // over/under counters and limits
  localparam int WLEN_WIDTH          = 16;   // window_length register
  localparam int INDEX_WIDTH_DEFAULT = 16;   // sample index width

  // Configuration port
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 63;

  // Divider sequencing: one quotient bit per cycle
  localparam int DIV_STEPS     = MSE_WIDTH;
  localparam int DIV_CNT_WIDTH = $clog2(DIV_STEPS);

  localparam logic [MSE_WIDTH-1:0] MSE_MAX = '1;
  localparam logic [CNT_WIDTH-1:0] CNT_MAX = '1;

  // Reset values of the configuration registers
  localparam logic [WLEN_WIDTH-1:0] WINDOW_LENGTH_RST      = WLEN_WIDTH'(4096);
  localparam logic [MSE_WIDTH-1:0]  DETECT_THRESHOLD_RST   = '1;
  localparam logic [MSE_WIDTH-1:0]  CLEAR_THRESHOLD_RST    = '0;
  localparam logic [CNT_WIDTH-1:0]  DETECT_COUNT_LIMIT_RST = CNT_WIDTH'(10);
  localparam logic [CNT_WIDTH-1:0]  CLEAR_COUNT_LIMIT_RST  = CNT_WIDTH'(100);

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_WINDOW_LENGTH      = 3'd0,
    REG_DETECT_THRESHOLD   = 3'd1,
    REG_CLEAR_THRESHOLD    = 3'd2,
    REG_DETECT_COUNT_LIMIT = 3'd3,
    REG_CLEAR_COUNT_LIMIT  = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_DIVIDE,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] measured;
    logic signed [SAMPLE_WIDTH-1:0] predicted;
    logic                           armed;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] estimate;
    logic [MSE_WIDTH-1:0]           mse;
    logic                           attack_flag;
    logic [MSE_WIDTH-1:0]           peak_mse;
  } out_item_t;

endpackage

/* hdl/windowed_mse_attack_detector.sv */
// windowed_mse_attack_detector: top level. Squares the prediction error,
// keeps a saturating window sum, divides it bit-serially and runs the flag logic.
// Depends on wmse_pkg.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------------
//   in      | input     | in_valid / in_stall | in_data  (measured, predicted, armed)
//   out     | output    | out_valid/out_stall | out_data (estimate, mse, flag, peak)
//   cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// Sequence: an armed transaction is squared, accumulated, divided by the
// restoring divider (one quotient bit per cycle) and then used to update
// state; a disarmed one goes straight to the update step.
// Reset: synchronous rst clears window state, flag and peak; sets register defaults.
// Stalls: the result sits in an output register, so a stalled output does not
// block the next transaction from being accepted and worked on; only the final
// update step waits for the output register to be free.

module windowed_mse_attack_detector #(
  parameter int INDEX_WIDTH = wmse_pkg::INDEX_WIDTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  wmse_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output wmse_pkg::out_item_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [wmse_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [wmse_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

  localparam int SW        = wmse_pkg::SAMPLE_WIDTH;
  localparam int PW        = 2 * SW;                    // squared error width
  localparam int MW        = wmse_pkg::MSE_WIDTH;
  localparam int CW        = wmse_pkg::CNT_WIDTH;
  localparam int DIV_WIDTH = INDEX_WIDTH + 1;           // divisor = index + 1
  localparam int CMP_WIDTH = (INDEX_WIDTH > wmse_pkg::WLEN_WIDTH) ?
                             INDEX_WIDTH : wmse_pkg::WLEN_WIDTH;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [wmse_pkg::WLEN_WIDTH-1:0] window_length;
  logic [MW-1:0]                   detect_threshold;
  logic [MW-1:0]                   clear_threshold;
  logic [CW-1:0]                   detect_count_limit;
  logic [CW-1:0]                   clear_count_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length      <= wmse_pkg::WINDOW_LENGTH_RST;
      detect_threshold   <= wmse_pkg::DETECT_THRESHOLD_RST;
      clear_threshold    <= wmse_pkg::CLEAR_THRESHOLD_RST;
      detect_count_limit <= wmse_pkg::DETECT_COUNT_LIMIT_RST;
      clear_count_limit  <= wmse_pkg::CLEAR_COUNT_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wmse_pkg::REG_WINDOW_LENGTH: begin
          window_length <= cfg_data[wmse_pkg::WLEN_WIDTH-1:0];
        end
        wmse_pkg::REG_DETECT_THRESHOLD: begin
          detect_threshold <= cfg_data[MW-1:0];
        end
        wmse_pkg::REG_CLEAR_THRESHOLD: begin
          clear_threshold <= cfg_data[MW-1:0];
        end
        wmse_pkg::REG_DETECT_COUNT_LIMIT: begin
          detect_count_limit <= cfg_data[CW-1:0];
        end
        wmse_pkg::REG_CLEAR_COUNT_LIMIT: begin
          clear_count_limit <= cfg_data[CW-1:0];
        end
        default: begin
          // unmapped index: write dropped
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Control state and window state
  // ---------------------------------------------------------------------------
  wmse_pkg::state_t             state, state_next;
  logic [wmse_pkg::DIV_CNT_WIDTH-1:0] div_cnt;

  logic [MW-1:0]          error_sum;
  logic [INDEX_WIDTH-1:0] sample_index;
  logic [CW-1:0]          over_count;
  logic [CW-1:0]          under_count;
  logic                   flag_reg;
  logic [MW-1:0]          peak_reg;

  // Payload registers (no reset)
  wmse_pkg::in_item_t     sample;
  logic [PW-1:0]          sq;
  logic [MW-1:0]          quo;       // dividend shifts out, quotient shifts in
  logic [DIV_WIDTH-1:0]   rem;
  logic [DIV_WIDTH-1:0]   divisor;

  logic accept;
  logic out_free;
  logic upd_fire;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      wmse_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = in_data.armed ? wmse_pkg::ST_SQUARE : wmse_pkg::ST_UPDATE;
        end
      end
      wmse_pkg::ST_SQUARE: state_next = wmse_pkg::ST_ACCUM;
      wmse_pkg::ST_ACCUM:  state_next = wmse_pkg::ST_DIVIDE;
      wmse_pkg::ST_DIVIDE: begin
        if (div_cnt == '0) begin
          state_next = wmse_pkg::ST_UPDATE;
        end
      end
      wmse_pkg::ST_UPDATE: begin
        if (out_free) begin
          state_next = wmse_pkg::ST_IDLE;
        end
      end
      default: state_next = wmse_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_stall = (state != wmse_pkg::ST_IDLE);
    accept   = in_valid && !in_stall;
    out_free = !out_valid || !out_stall;
    upd_fire = (state == wmse_pkg::ST_UPDATE) && out_free;
  end

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  logic signed [SW:0] diff;
  logic [SW:0]        mag_full;
  logic [SW-1:0]      mag;
  logic [PW-1:0]      sq_prod;
  logic [MW:0]        sum_wide;
  logic [MW-1:0]      sum_sat;

  // |pred - meas| fits SW bits; square fits 2*SW bits
  always_comb begin
    diff     = $signed({sample.predicted[SW-1], sample.predicted})
             - $signed({sample.measured[SW-1], sample.measured});
    mag_full = diff[SW] ? 
               (SW+1)'(-diff) : (SW+1)'(diff);
    mag      = mag_full[SW-1:0];
    sq_prod  = PW'(mag) * PW'(mag);
    // error_sum never exceeds MSE_MAX, so a carry into the top bit means saturate
    sum_wide = {1'b0, error_sum} + (MW+1)'(sq);
    sum_sat  = sum_wide[MW] ? wmse_pkg::MSE_MAX : sum_wide[MW-1:0];
  end

  // Restoring divider step
  logic [DIV_WIDTH:0]   rem_sh;
  logic [DIV_WIDTH:0]   rem_diff;
  logic                 fits;
  logic [DIV_WIDTH-1:0] rem_next;
  logic [MW-1:0]        quo_next;

  always_comb begin
    rem_sh   = {rem, quo[MW-1]};
    rem_diff = rem_sh - {1'b0, divisor};
    fits     = (rem_sh >= {1'b0, divisor});
    rem_next = fits ? rem_diff[DIV_WIDTH-1:0] : rem_sh[DIV_WIDTH-1:0];
    quo_next = {quo[MW-2:0], fits};
  end

  // Window, counter and flag update
  logic [MW-1:0]          mse_v;
  logic [INDEX_WIDTH-1:0] idx_inc;
  logic                   win_end;
  logic [MW-1:0]          sum_u;
  logic [INDEX_WIDTH-1:0] idx_u;
  logic [CW-1:0]          over_u;
  logic [CW-1:0]          under_u;
  logic                   flag_u;
  logic [MW-1:0]          peak_u;

  always_comb begin
    mse_v   = sample.armed ? quo : '0;
    idx_inc = sample_index + INDEX_WIDTH'(1);
    win_end = (CMP_WIDTH'(idx_inc) >= CMP_WIDTH'(window_length));
    sum_u   = error_sum;
    idx_u   = idx_inc;
    over_u  = over_count;
    under_u = under_count;
    flag_u  = flag_reg;
    peak_u  = peak_reg;
    if (!sample.armed) begin
      sum_u   = '0;
      idx_u   = '0;
      over_u  = '0;
      under_u = '0;
    end else begin
      if (mse_v > peak_reg) begin
        peak_u = mse_v;
      end
      if (win_end) begin
        sum_u   = '0;
        idx_u   = '0;
        over_u  = '0;
        under_u = '0;
      end
      if (mse_v > detect_threshold && over_u != wmse_pkg::CNT_MAX) begin
        over_u = over_u + CW'(1);
      end
      if (over_u > detect_count_limit) begin
        flag_u = 1'b1;
      end
      if (flag_u) begin
        if (mse_v < clear_threshold && under_u != wmse_pkg::CNT_MAX) begin
          under_u = under_u + CW'(1);
        end
        // flag drop clears sum and counters but keeps the index
        if (under_u > clear_count_limit) begin
          sum_u   = '0;
          over_u  = '0;
          under_u = '0;
          flag_u  = 1'b0;
        end
      end
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= wmse_pkg::ST_IDLE;
      div_cnt      <= '0;
      out_valid    <= 1'b0;
      error_sum    <= '0;
      sample_index <= '0;
      over_count   <= '0;
      under_count  <= '0;
      flag_reg     <= 1'b0;
      peak_reg     <= '0;
    end else begin
      state <= state_next;
      if (state == wmse_pkg::ST_ACCUM) begin
        error_sum <= sum_sat;
        div_cnt   <= wmse_pkg::DIV_CNT_WIDTH'(wmse_pkg::DIV_STEPS - 1);
      end else if (state == wmse_pkg::ST_DIVIDE) begin
        div_cnt <= div_cnt - wmse_pkg::DIV_CNT_WIDTH'(1);
      end
      if (upd_fire) begin
        error_sum    <= sum_u;
        sample_index <= idx_u;
        over_count   <= over_u;
        under_count  <= under_u;
        flag_reg     <= flag_u;
        peak_reg     <= peak_u;
        out_valid    <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      sample <= in_data;
    end
    if (state == wmse_pkg::ST_SQUARE) begin
      sq <= sq_prod;
    end
    if (state == wmse_pkg::ST_ACCUM) begin
      quo     <= sum_sat;
      rem     <= '0;
      divisor <= DIV_WIDTH'(sample_index) + DIV_WIDTH'(1);
    end else if (state == wmse_pkg::ST_DIVIDE) begin
      quo <= quo_next;
      rem <= rem_next;
    end
    if (upd_fire) begin
      out_data.estimate    <= sample.armed ? sample.predicted : sample.measured;
      out_data.mse         <= mse_v;
      out_data.attack_flag <= flag_u;
      out_data.peak_mse    <= peak_u;
    end
  end

endmodule

/* hdl/wmse_checker.sv */
// wmse_checker: port-level assertions for windowed_mse_attack_detector, and
// the bind that attaches them. Depends on wmse_pkg and the top level.

module wmse_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input wmse_pkg::out_item_t out_data
);

  logic                           seen;
  logic [wmse_pkg::MSE_WIDTH-1:0] last_peak;

  // peak of the last delivered transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      seen      <= 1'b0;
      last_peak <= '0;
    end else if (out_valid && !out_stall) begin
      seen      <= 1'b1;
      last_peak <= out_data.peak_mse;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction taken while one is in flight");

  a_mse_le_peak: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.mse <= out_data.peak_mse)
    else $error("mse above reported peak");

  a_peak_monotonic: assert property (@(posedge clk) disable iff (rst)
    out_valid && seen |-> out_data.peak_mse >= last_peak)
    else $error("peak decreased");

  a_result_frees_input: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_stall)
    else $error("result posted while input still busy");

endmodule

bind windowed_mse_attack_detector wmse_checker u_wmse_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
